FILE: hw/rtl/smab_pkg.sv
// ----------------------------------------------------------------------------
// smab_pkg
// shared types and command codes of the serial memory access bridge
// ----------------------------------------------------------------------------
package smab_pkg;

  // command and answer bytes on the serial link
  localparam logic [7:0] CMD_PING     = 8'h10;
  localparam logic [7:0] CMD_PONG     = 8'h11;
  localparam logic [7:0] CMD_DISCOVER = 8'h12;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_WRITE    = 8'h21;
  localparam logic [7:0] CMD_SET      = 8'h22;
  localparam logic [7:0] CMD_GPIO     = 8'h23;
  localparam logic [7:0] CMD_BOOT     = 8'h40;
  localparam logic [7:0] CMD_BAUD     = 8'h50;
  localparam logic [7:0] ANS_OK       = 8'hF0;
  localparam logic [7:0] ANS_ERR      = 8'hFE;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_DISCOVER = 4'd0,
    PH_IDLE     = 4'd1,
    PH_ADDR     = 4'd2,
    PH_LEN      = 4'd3,
    PH_WDATA    = 4'd4,
    PH_FILL     = 4'd5,
    PH_RWAIT    = 4'd6,
    PH_BAUD     = 4'd7,
    PH_BOOTED   = 4'd8
  } smab_phase_t;

  typedef enum logic [1:0] {
    PC_NONE  = 2'd0,
    PC_READ  = 2'd1,
    PC_WRITE = 2'd2,
    PC_SET   = 2'd3
  } smab_pend_t;

  typedef enum logic [2:0] {
    K_TX    = 3'd0,
    K_RREQ  = 3'd1,
    K_WRITE = 3'd2,
    K_FILL  = 3'd3,
    K_BAUD  = 3'd4,
    K_BOOT  = 3'd5
  } smab_kind_t;

  // what one queue entry expands to on the result side
  typedef enum logic [2:0] {
    P_TX      = 3'd0,  // transmit byte
    P_RREQ    = 3'd1,  // read request
    P_WRITE   = 3'd2,  // memory write
    P_FILL_OK = 3'd3,  // fill request, then ok
    P_BAUD_OK = 3'd4,  // ok, then set baud
    P_BOOT    = 3'd5,  // boot
    P_TX_RREQ = 3'd6   // read data byte, then next read request
  } smab_pattern_t;

  typedef struct packed {
    smab_pattern_t pattern;
    logic          port;
    logic [7:0]    data;
    logic [63:0]   address;
    logic [63:0]   length;
    logic [31:0]   baud;
  } smab_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } smab_qstat_t;

  typedef struct packed {
    smab_kind_t  kind;
    logic        tx_port;
    logic [7:0]  data;
    logic [63:0] address;
    logic [63:0] length;
    logic [31:0] baud;
    logic        last;
  } smab_beat_t;

endpackage

FILE: hw/rtl/smab_front.sv
// ----------------------------------------------------------------------------
// smab_front
// command decoder: tracks the protocol phase, gathers operands, queues work
// ----------------------------------------------------------------------------
module smab_front
  import smab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic        in_port,
  input  logic [7:0]  in_value,
  input  logic [7:0]  in_gpio,
  output logic        push,
  output smab_entry_t entry
);

  smab_phase_t phase_r, phase_nxt;
  logic        active_r, active_nxt;
  smab_pend_t  pend_r, pend_nxt;
  logic [63:0] cursor_r, cursor_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        acc;
  logic        cmd_ok;
  logic        idx_last;
  logic        rem_one;
  logic [5:0]  shamt;
  logic [63:0] cur_ins;
  logic [63:0] rem_ins;
  logic [63:0] cur_inc;
  logic [63:0] rem_dec;

  assign acc      = in_valid & in_ready;
  assign cmd_ok   = !in_op && (in_port == active_r);
  assign idx_last = (idx_r == 3'd7);
  assign rem_one  = (remain_r == 64'd1);
  assign shamt    = {idx_r, 3'b000};
  assign cur_ins  = cursor_r | ({56'd0, in_value} << shamt);
  assign rem_ins  = remain_r | ({56'd0, in_value} << shamt);
  assign cur_inc  = cursor_r + 64'd1;
  assign rem_dec  = remain_r - 64'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (phase_r)
        PH_DISCOVER: begin
          if (!in_op && in_value == CMD_DISCOVER) phase_nxt = PH_IDLE;
        end
        PH_RWAIT: begin
          if (in_op && rem_one) phase_nxt = PH_IDLE;
        end
        PH_IDLE: begin
          if (cmd_ok) begin
            case (in_value)
              CMD_READ, CMD_WRITE, CMD_SET: phase_nxt = PH_ADDR;
              CMD_BAUD:                     phase_nxt = PH_BAUD;
              CMD_BOOT:                     phase_nxt = PH_BOOTED;
              default:                      phase_nxt = PH_IDLE;
            endcase
          end
        end
        PH_ADDR: begin
          if (cmd_ok && idx_last) phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (cmd_ok && idx_last) begin
            if (pend_r == PC_SET)       phase_nxt = PH_FILL;
            else if (rem_ins == 64'd0)  phase_nxt = PH_IDLE;
            else if (pend_r == PC_READ) phase_nxt = PH_RWAIT;
            else                        phase_nxt = PH_WDATA;
          end
        end
        PH_WDATA: begin
          if (cmd_ok && rem_one) phase_nxt = PH_IDLE;
        end
        PH_FILL: begin
          if (cmd_ok) phase_nxt = PH_IDLE;
        end
        PH_BAUD: begin
          if (cmd_ok && idx_last) phase_nxt = PH_IDLE;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // queue entry and operand registers
  always_comb begin
    push       = 1'b0;
    entry      = '0;
    entry.port = active_r;
    active_nxt = active_r;
    pend_nxt   = pend_r;
    cursor_nxt = cursor_r;
    remain_nxt = remain_r;
    idx_nxt    = idx_r;
    if (acc) begin
      case (phase_r)
        PH_DISCOVER: begin
          if (!in_op && in_value == CMD_DISCOVER) begin
            active_nxt    = in_port;
            push          = 1'b1;
            entry.pattern = P_TX;
            entry.port    = in_port;
            entry.data    = ANS_OK;
          end
        end
        PH_RWAIT: begin
          if (in_op) begin
            push          = 1'b1;
            entry.pattern = rem_one ? P_TX : P_TX_RREQ;
            entry.data    = in_value;
            entry.address = cur_inc;
            cursor_nxt    = cur_inc;
            remain_nxt    = rem_dec;
          end
        end
        PH_IDLE: begin
          if (cmd_ok) begin
            case (in_value)
              CMD_PING: begin
                push          = 1'b1;
                entry.pattern = P_TX;
                entry.data    = CMD_PONG;
              end
              CMD_GPIO: begin
                push          = 1'b1;
                entry.pattern = P_TX;
                entry.data    = in_gpio;
              end
              CMD_READ, CMD_WRITE, CMD_SET: begin
                pend_nxt   = (in_value == CMD_READ)  ? PC_READ :
                             (in_value == CMD_WRITE) ? PC_WRITE : PC_SET;
                cursor_nxt = '0;
                remain_nxt = '0;
                idx_nxt    = '0;
              end
              CMD_BAUD: begin
                remain_nxt = '0;
                idx_nxt    = '0;
              end
              CMD_BOOT: begin
                push          = 1'b1;
                entry.pattern = P_BOOT;
              end
              default: begin
                push          = 1'b1;
                entry.pattern = P_TX;
                entry.data    = ANS_ERR;
              end
            endcase
          end
        end
        PH_ADDR: begin
          if (cmd_ok) begin
            cursor_nxt = cur_ins;
            idx_nxt    = idx_r + 3'd1;
          end
        end
        PH_LEN: begin
          if (cmd_ok) begin
            remain_nxt = rem_ins;
            idx_nxt    = idx_r + 3'd1;
            if (idx_last && pend_r == PC_READ && rem_ins != 64'd0) begin
              push          = 1'b1;
              entry.pattern = P_RREQ;
              entry.address = cursor_r;
            end
          end
        end
        PH_WDATA: begin
          if (cmd_ok) begin
            push          = 1'b1;
            entry.pattern = P_WRITE;
            entry.data    = in_value;
            entry.address = cursor_r;
            cursor_nxt    = cur_inc;
            remain_nxt    = rem_dec;
          end
        end
        PH_FILL: begin
          if (cmd_ok) begin
            push          = 1'b1;
            entry.pattern = P_FILL_OK;
            entry.data    = in_value;
            entry.address = cursor_r;
            entry.length  = remain_r;
          end
        end
        PH_BAUD: begin
          if (cmd_ok) begin
            remain_nxt = rem_ins;
            idx_nxt    = idx_r + 3'd1;
            if (idx_last) begin
              push = 1'b1;
              if (active_r) begin
                entry.pattern = P_BAUD_OK;
                entry.baud    = rem_ins[31:0];
              end else begin
                entry.pattern = P_TX;
                entry.data    = ANS_ERR;
              end
            end
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DISCOVER;
      active_r <= 1'b0;
      pend_r   <= PC_NONE;
      cursor_r <= '0;
      remain_r <= '0;
      idx_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      cursor_r <= cursor_nxt;
      remain_r <= remain_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

FILE: hw/rtl/smab_queue.sv
// ----------------------------------------------------------------------------
// smab_queue
// small first-in first-out queue of decoded work between front and back
// ----------------------------------------------------------------------------
module smab_queue
  import smab_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  smab_entry_t wr_entry,
  input  logic        pop,
  output smab_entry_t head,
  output smab_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  smab_entry_t      slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign head       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/smab_back.sv
// ----------------------------------------------------------------------------
// smab_back
// result sequencer: expands queued work into result beats, output register
// ----------------------------------------------------------------------------
module smab_back
  import smab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  smab_entry_t head,
  input  smab_qstat_t stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output smab_beat_t  out_beat
);

  logic       valid_r, valid_nxt;
  logic       sub_r, sub_nxt;
  smab_beat_t beat_r;
  smab_beat_t beat;
  logic       two_beat;
  logic       load;
  logic       take;

  // beat selected by the entry pattern and the half being sent
  always_comb begin
    beat         = '0;
    beat.kind    = K_TX;
    beat.last    = 1'b1;
    two_beat     = 1'b0;
    case (head.pattern)
      P_TX: begin
        beat.tx_port = head.port;
        beat.data    = head.data;
      end
      P_RREQ: begin
        beat.kind    = K_RREQ;
        beat.address = head.address;
      end
      P_WRITE: begin
        beat.kind    = K_WRITE;
        beat.data    = head.data;
        beat.address = head.address;
      end
      P_FILL_OK: begin
        two_beat = 1'b1;
        if (!sub_r) begin
          beat.kind    = K_FILL;
          beat.data    = head.data;
          beat.address = head.address;
          beat.length  = head.length;
          beat.last    = 1'b0;
        end else begin
          beat.tx_port = head.port;
          beat.data    = ANS_OK;
        end
      end
      P_BAUD_OK: begin
        two_beat = 1'b1;
        if (!sub_r) begin
          beat.tx_port = head.port;
          beat.data    = ANS_OK;
          beat.last    = 1'b0;
        end else begin
          beat.kind = K_BAUD;
          beat.baud = head.baud;
        end
      end
      P_BOOT: begin
        beat.kind = K_BOOT;
      end
      P_TX_RREQ: begin
        two_beat = 1'b1;
        if (!sub_r) begin
          beat.tx_port = head.port;
          beat.data    = head.data;
          beat.last    = 1'b0;
        end else begin
          beat.kind    = K_RREQ;
          beat.address = head.address;
        end
      end
      default: beat.last = 1'b1;
    endcase
  end

  assign load      = !valid_r || out_ready;
  assign take      = load && !stat.empty;
  assign pop       = take && (!two_beat || sub_r);
  assign valid_nxt = load ? !stat.empty : valid_r;
  assign sub_nxt   = take ? (two_beat && !sub_r) : sub_r;

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= beat;
    end
  end

endmodule

FILE: hw/rtl/serial_memory_access_bridge.sv
// ----------------------------------------------------------------------------
// serial_memory_access_bridge
// serial command interpreter driving memory, gpio, baud and boot requests
// ----------------------------------------------------------------------------
// usage
//   in_* carries one beat per received serial byte (tuser op = 0) or per
//   returned memory read byte (tuser op = 1); tuser port names the uart.
//   out_* carries result beats: transmit bytes, memory read requests, memory
//   writes, fill requests, set baud and boot; tlast marks the last result
//   caused by one input beat (one input beat causes zero, one or two).
// throughput
//   one input beat per cycle while the queue has room and one result beat per
//   cycle while out_tready is high; an input beat that causes two results
//   takes two result beats, and the decode queue soaks up the difference.
// data path
//   an accepted input beat is written into the queue, then loaded into the
//   output register that drives out_tvalid.
// reset
//   rst_n low for one clock clears the decoder to await discover, empties
//   the queue and drops out_tvalid; no clearing pass is needed.
// stall
//   while out_tready is low the output register holds its beat; the queue
//   keeps taking input until its QDEPTH entries are used, then
//   in_tready falls until the result sequencer pops an entry.
// ----------------------------------------------------------------------------
module serial_memory_access_bridge
  import smab_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [7:0] value, [15:8] gpio_level
  input  logic [1:0]   in_tuser,   // [0] op, [1] port
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // [7:0] data, [71:8] address,
                                   // [135:72] length, [167:136] baud
  output logic [3:0]   out_tuser,  // [2:0] kind, [3] tx_port
  output logic         out_tlast
);

  logic        push;
  logic        pop;
  smab_entry_t entry;
  smab_entry_t head;
  smab_qstat_t q_stat;
  smab_beat_t  beat;

  // input stalls only when the decode queue is full
  assign in_tready = !q_stat.full;

  // front: decode and operand gathering
  smab_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser[0]),
    .in_port  (in_tuser[1]),
    .in_value (in_tdata[7:0]),
    .in_gpio  (in_tdata[15:8]),
    .push     (push),
    .entry    (entry)
  );

  // decoupling queue between decode and result sequencing
  smab_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: expands each entry into one or two result beats
  smab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (q_stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_beat  (beat)
  );

  // result packing, first field in the low bits
  assign out_tdata = {beat.baud, beat.length, beat.address, beat.data};
  assign out_tuser = {beat.tx_port, beat.kind};
  assign out_tlast = beat.last;

`ifndef SYNTHESIS
  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.empty && q_stat.full))
    else $error("queue reports empty and full at once");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("decoder pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("result sequencer popped an empty queue");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2:0] <= K_BOOT))
    else $error("result beat carries an undefined kind");
`endif

endmodule
